// File: sv/bsds_pkg.sv
// bsds_pkg: shared types and constants of the brush stroke dab spacer
// command codes, configuration register indexes, sequencer states, field widths
// no dependencies
package bsds_pkg;

  localparam int COORD_W   = 16;
  localparam int SIZE_W    = 16;
  localparam int SPACING_W = 12;
  localparam int CFG_W     = 16;
  localparam int STEP_PROD_W = SIZE_W + SPACING_W;
  localparam int STEP_SHIFT  = 8;
  localparam int STEP_W      = STEP_PROD_W - STEP_SHIFT;

  localparam logic [STEP_W-1:0]    STEP_FLOOR    = STEP_W'(16);
  localparam logic [SIZE_W-1:0]    SIZE_RESET    = SIZE_W'(800);
  localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(26);

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_END   = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_BRUSH_SIZE  = 1'b0,
    REG_DAB_SPACING = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEGIN,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_CHECK,
    S_MULX,
    S_DIVX,
    S_MULY,
    S_DIVY,
    S_EMIT
  } state_e;

endpackage

// File: sv/brush_stroke_dab_spacer_unit.sv
// brush_stroke_dab_spacer_unit: top level of the brush stroke dab spacer
// sequencer around one shared multiplier and one shared subtractor
// depends on bsds_pkg
//
// Pointer events enter on in_valid_i / in_ready_o with cmd_i, pos_x_i and
// pos_y_i; dab centres leave on out_valid_o / out_ready_i with dab_x_o,
// dab_y_o and last_dab_o, which marks the final dab of an event. Registers
// are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them
// only while the block is idle, which the block itself does not enforce.
// One item is worked on at a time and in_ready_o is high only when idle.
// An end event or an ignored move leaves the block idle. A begin event moves to
// S_BEGIN, which loads its dab into the output register once that is free.
// A move on an armed stroke runs the squares, the 17 step bit-serial square root
// and the distance check, then for each dab one multiply and 16 restoring divide
// steps per axis, after which S_EMIT hands the dab to the output register.
// The output register holds one dab; while the receiver stalls, the sequencer
// waits with the next dab, and a finished last dab does not block new items.
// Reset clears the stroke, the stored position and the output valid, and
// loads brush_size 800 and dab_spacing 26.
module brush_stroke_dab_spacer_unit
  import bsds_pkg::*;
#(
  parameter int MAX_DABS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [COORD_W-1:0] pos_x_i,
  input  logic [COORD_W-1:0] pos_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COORD_W-1:0] dab_x_o,
  output logic [COORD_W-1:0] dab_y_o,
  output logic               last_dab_o
);

  localparam int CW   = COORD_W;
  localparam int DW   = CW + 1;
  localparam int RW   = CW + 2;
  localparam int SW   = CW + 4;
  localparam int SQW  = 2 * CW + 2;
  localparam int PW   = 2 * CW + 1;
  localparam int ACW  = ((DW > STEP_W) ? DW : STEP_W) + 1;
  localparam int IW   = $clog2(MAX_DABS + 1);
  localparam int CNW  = $clog2(CW + 2);

  state_e state_q, state_d;

  logic [SIZE_W-1:0]    size_q;
  logic [SPACING_W-1:0] spacing_q;
  logic                 active_q;
  logic [CW-1:0]        last_x_q, last_y_q;
  logic [CW-1:0]        new_x_q, new_y_q;
  logic [CW-1:0]        mag_x_q, mag_y_q;
  logic                 neg_x_q, neg_y_q;
  logic [STEP_W-1:0]    step_q;
  logic [SQW-1:0]       sq_q;
  logic [RW-1:0]        rem_q;
  logic [DW-1:0]        root_q;
  logic [CNW-1:0]       cnt_q;
  logic [ACW-1:0]       acc_q;
  logic [IW-1:0]        idx_q;
  logic [CW-1:0]        res_x_q;
  logic                 out_valid_q;
  logic [COORD_W-1:0]   dab_x_q, dab_y_q;
  logic                 last_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 out_load;
  logic [CW-1:0]        px, py;
  logic [CW:0]          dx, dy;
  logic [CW-1:0]        mul_a;
  logic [DW-1:0]        mul_b;
  logic [PW-1:0]        mul_p;
  logic [SW-1:0]        sub_a, sub_b;
  logic [SW:0]          diff;
  logic                 ge;
  logic [STEP_W-1:0]    step_raw, step_c;
  logic [ACW-1:0]       acc_nxt;
  logic                 is_last;
  logic                 dist_ok;
  logic [CW-1:0]        off;
  logic [CW-1:0]        res_y;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign px = CW'(pos_x_i);
  assign py = CW'(pos_y_i);
  assign dx = {1'b0, px} - {1'b0, last_x_q};
  assign dy = {1'b0, py} - {1'b0, last_y_q};

  // shared units
  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge    = ~diff[SW];

  assign step_raw  = mul_p[STEP_PROD_W-1:STEP_SHIFT];
  assign step_c    = (step_raw < STEP_FLOOR) ? STEP_FLOOR : step_raw;

  assign dist_ok = ACW'(root_q) >= ACW'(step_q);
  assign acc_nxt = acc_q + ACW'(step_q);
  assign is_last = (idx_q == IW'(MAX_DABS)) || (acc_nxt > ACW'(root_q));

  assign off   = sq_q[CW-1:0];
  assign res_y = neg_y_q ? (last_y_q - off) : (last_y_q + off);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_BEGIN) begin
            state_d = S_BEGIN;
          end else if (cmd_i == CMD_MOVE && active_q) begin
            state_d = S_SQX;
          end
        end
      end
      S_BEGIN: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SQRT;
      S_SQRT: begin
        if (cnt_q == CNW'(CW)) state_d = S_CHECK;
      end
      S_CHECK: state_d = dist_ok ? S_MULX : S_IDLE;
      S_MULX:  state_d = S_DIVX;
      S_DIVX: begin
        if (cnt_q == CNW'(CW - 1)) state_d = S_MULY;
      end
      S_MULY:  state_d = S_DIVY;
      S_DIVY: begin
        if (cnt_q == CNW'(CW - 1)) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = is_last ? S_IDLE : S_MULX;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // unit operand selection and handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sub_a      = '0;
    sub_b      = '0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_BEGIN: out_load = out_free;
      S_SQX: begin
        mul_a = mag_x_q;
        mul_b = DW'(mag_x_q);
      end
      S_SQY: begin
        mul_a = mag_y_q;
        mul_b = DW'(mag_y_q);
      end
      S_SQRT: begin
        mul_a = CW'(size_q);
        mul_b = DW'(spacing_q);
        sub_a = SW'({rem_q, sq_q[SQW-1 -: 2]});
        sub_b = SW'({root_q, 2'b01});
      end
      S_MULX: begin
        mul_a = mag_x_q;
        mul_b = acc_q[DW-1:0];
      end
      S_MULY: begin
        mul_a = mag_y_q;
        mul_b = acc_q[DW-1:0];
      end
      S_DIVX, S_DIVY: begin
        sub_a = SW'({rem_q[DW-1:0], sq_q[CW-1]});
        sub_b = SW'(root_q);
      end
      S_EMIT:  out_load = out_free;
      S_CHECK: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SIZE_RESET;
      spacing_q   <= SPACING_RESET;
      active_q    <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BRUSH_SIZE:  size_q    <= cfg_data_i[SIZE_W-1:0];
          REG_DAB_SPACING: spacing_q <= cfg_data_i[SPACING_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && cmd_i == CMD_BEGIN) begin
        active_q <= 1'b1;
        last_x_q <= px;
        last_y_q <= py;
      end else if (in_acc && cmd_i == CMD_END) begin
        active_q <= 1'b0;
      end
      if (state_q == S_EMIT && out_free && is_last) begin
        last_x_q <= new_x_q;
        last_y_q <= new_y_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_x_q <= px;
      new_y_q <= py;
      neg_x_q <= dx[CW];
      neg_y_q <= dy[CW];
      mag_x_q <= dx[CW] ? CW'(-dx) : dx[CW-1:0];
      mag_y_q <= dy[CW] ? CW'(-dy) : dy[CW-1:0];
    end
    unique case (state_q)
      S_SQX: begin
        sq_q   <= SQW'(mul_p);
      end
      S_SQY: begin
        sq_q   <= sq_q + SQW'(mul_p);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      S_SQRT: begin
        step_q <= step_c;
        rem_q  <= ge ? diff[RW-1:0] : sub_a[RW-1:0];
        root_q <= {root_q[DW-2:0], ge};
        sq_q   <= {sq_q[SQW-3:0], 2'b00};
        cnt_q  <= cnt_q + CNW'(1);
      end
      S_CHECK: begin
        acc_q <= ACW'(step_q);
        idx_q <= IW'(1);
      end
      S_MULX, S_MULY: begin
        rem_q <= RW'(mul_p[PW-1:CW]);
        sq_q  <= SQW'(mul_p);
        cnt_q <= '0;
      end
      S_DIVX, S_DIVY: begin
        rem_q <= ge ? diff[RW-1:0] : sub_a[RW-1:0];
        sq_q  <= {sq_q[SQW-2:0], ge};
        cnt_q <= cnt_q + CNW'(1);
        if (state_q == S_DIVX && cnt_q == CNW'(CW - 1)) begin
          res_x_q <= neg_x_q ? (last_x_q - {sq_q[CW-2:0], ge})
                             : (last_x_q + {sq_q[CW-2:0], ge});
        end
      end
      S_EMIT: begin
        if (out_free) begin
          acc_q <= acc_nxt;
          idx_q <= idx_q + IW'(1);
        end
      end
      S_IDLE, S_BEGIN: ;
      default: ;
    endcase
    if (out_load) begin
      if (state_q == S_BEGIN) begin
        dab_x_q <= COORD_W'(last_x_q);
        dab_y_q <= COORD_W'(last_y_q);
        last_q  <= 1'b1;
      end else begin
        dab_x_q <= COORD_W'(res_x_q);
        dab_y_q <= COORD_W'(res_y);
        last_q  <= is_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign dab_x_o     = dab_x_q;
  assign dab_y_o     = dab_y_q;
  assign last_dab_o  = last_q;

endmodule

// File: sv/bsds_checker.sv
// bsds_checker: port-level assertions for brush_stroke_dab_spacer_unit
// bound to the top level at the end of this file
// depends on bsds_pkg
module bsds_checker
  import bsds_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          cmd_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [COORD_W-1:0]  dab_x_o,
  input logic [COORD_W-1:0]  dab_y_o,
  input logic                last_dab_o
);

  // a begin item makes the block busy for the following cycle
  a_begin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_BEGIN |=> !in_ready_o)
    else $error("block ready right after a begin item");

  // a begin item yields a single final dab once the output register is free
  a_begin_dab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_BEGIN ##1 (!out_valid_o || out_ready_i)
      |=> out_valid_o && last_dab_o)
    else $error("begin item gave no final dab");

  // an end item leaves the block idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_END |=> in_ready_o)
    else $error("block busy after an end item");

  // a stalled dab holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dab_x_o)
      && $stable(dab_y_o) && $stable(last_dab_o))
    else $error("stalled dab changed");

endmodule

bind brush_stroke_dab_spacer_unit bsds_checker u_bsds_checker (.*);
